// ===== sv/ptb_pkg.sv =====
package ptb_pkg;

  // Default sizes of the piece table and the two byte stores.
  localparam int MAX_PIECES_DEF     = 64;
  localparam int ORIGINAL_DEPTH_DEF = 4096;
  localparam int APPEND_DEPTH_DEF   = 4096;

  // Fixed widths of the request and result fields.
  localparam int POS_W    = 14;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // Operation codes.
  localparam logic [2:0] OP_CLEAR  = 3'd0;
  localparam logic [2:0] OP_LOAD   = 3'd1;
  localparam logic [2:0] OP_INSERT = 3'd2;
  localparam logic [2:0] OP_ERASE  = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_STORE_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]        op;
    logic [POS_W-1:0]  position;
    logic [POS_W-1:0]  erase_length;
    logic [BYTE_W-1:0] data_byte;
    logic              last;
  } ptb_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   read_byte;
    logic [POS_W-1:0]    doc_length;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  piece_count;
  } ptb_out_t;

endpackage

// ===== sv/ptb_ram.sv =====
module ptb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/piece_table_text_buffer_unit.sv =====
// Channel   Direction  Payload     Handshake
// in_       input      ptb_in_t    in_valid / in_stall
// out_      output     ptb_out_t   out_valid / out_stall
//
// One request is worked at a time; in_stall stays high until its result is registered.
// A plain insert byte writes the append store, a load may first read the tail piece, and a read
// scans the table piece by piece. An insert commit scans and then shifts the table tail entry
// by entry; an erase scans once and then rebuilds and merges the table piece by piece. The
// piece table memory has a single read port. Reset is synchronous and empties the table;
// a stalled result holds in the output register.
module piece_table_text_buffer_unit
  import ptb_pkg::*;
#(
  parameter int MAX_PIECES     = MAX_PIECES_DEF,
  parameter int ORIGINAL_DEPTH = ORIGINAL_DEPTH_DEF,
  parameter int APPEND_DEPTH   = APPEND_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ptb_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output ptb_out_t out_data
);

  localparam int OFF_W = $clog2(ORIGINAL_DEPTH > APPEND_DEPTH ? ORIGINAL_DEPTH : APPEND_DEPTH);
  localparam int DW0   = $clog2(ORIGINAL_DEPTH + APPEND_DEPTH + 1);
  localparam int LEN_W = (DW0 > POS_W ? DW0 : POS_W) + 1;
  localparam int IDX_W = $clog2(MAX_PIECES);
  localparam int CNT_W = $clog2(MAX_PIECES + 1);
  localparam int OA_W  = $clog2(ORIGINAL_DEPTH);
  localparam int AA_W  = $clog2(APPEND_DEPTH);
  localparam int OF_W  = $clog2(ORIGINAL_DEPTH + 1);
  localparam int AF_W  = $clog2(APPEND_DEPTH + 1);
  localparam int ENT_W = 1 + OFF_W + LEN_W;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_GO       = 5'd1;
  localparam logic [4:0] S_SCAN_RD  = 5'd2;
  localparam logic [4:0] S_SCAN_EV  = 5'd3;
  localparam logic [4:0] S_TAIL_RD  = 5'd4;
  localparam logic [4:0] S_TAIL_EV  = 5'd5;
  localparam logic [4:0] S_LOAD_FIN = 5'd6;
  localparam logic [4:0] S_CMT      = 5'd7;
  localparam logic [4:0] S_CEND_FIN = 5'd8;
  localparam logic [4:0] S_CMID     = 5'd9;
  localparam logic [4:0] S_SH_RD    = 5'd10;
  localparam logic [4:0] S_SH_WR    = 5'd11;
  localparam logic [4:0] S_PUT      = 5'd12;
  localparam logic [4:0] S_EPRE     = 5'd13;
  localparam logic [4:0] S_ST_RD    = 5'd14;
  localparam logic [4:0] S_ST_EV    = 5'd15;
  localparam logic [4:0] S_ST_F2    = 5'd16;
  localparam logic [4:0] S_ST_END   = 5'd17;
  localparam logic [4:0] S_RFOUND   = 5'd18;
  localparam logic [4:0] S_RBYTE    = 5'd19;
  localparam logic [4:0] S_DONE     = 5'd20;

  localparam logic [1:0] RS_ORIG = 2'd1;
  localparam logic [1:0] RS_APP  = 2'd2;

  logic [4:0]          state_r, state_nxt;
  ptb_in_t             req_r, req_nxt;
  logic [LEN_W-1:0]    doc_r, doc_nxt;
  logic [CNT_W-1:0]    used_r, used_nxt;
  logic [OF_W-1:0]     ofill_r, ofill_nxt;
  logic [AF_W-1:0]     afill_r, afill_nxt;
  logic                pact_r, pact_nxt;
  logic [POS_W-1:0]    ppos_r, ppos_nxt;
  logic [AF_W-1:0]     pstart_r, pstart_nxt;
  logic [AF_W-1:0]     pcnt_r, pcnt_nxt;
  logic [AF_W-1:0]     cm_cnt_r, cm_cnt_nxt;
  logic [LEN_W-1:0]    cm_pos_r, cm_pos_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [LEN_W-1:0]    cons_r, cons_nxt;
  logic [LEN_W-1:0]    key_r, key_nxt;
  logic                ge_r, ge_nxt;
  logic                found_r, found_nxt;
  logic [CNT_W-1:0]    pi_r, pi_nxt;
  logic                p_src_r, p_src_nxt;
  logic [OFF_W-1:0]    p_off_r, p_off_nxt;
  logic [LEN_W-1:0]    p_len_r, p_len_nxt;
  logic                tail_match_r, tail_match_nxt;
  logic [CNT_W-1:0]    k_r, k_nxt;
  logic [CNT_W-1:0]    at_r, at_nxt;
  logic [CNT_W-1:0]    base_r, base_nxt;
  logic [1:0]          n_r, n_nxt;
  logic                three_r, three_nxt;
  logic [1:0]          step_r, step_nxt;
  logic [LEN_W-1:0]    split_r, split_nxt;
  logic [LEN_W-1:0]    lo_r, lo_nxt;
  logic [LEN_W-1:0]    hi_r, hi_nxt;
  logic [CNT_W-1:0]    w_r, w_nxt;
  logic [LEN_W-1:0]    a_r, a_nxt;
  logic [LEN_W-1:0]    b_r, b_nxt;
  logic                acc_v_r, acc_v_nxt;
  logic                acc_src_r, acc_src_nxt;
  logic [OFF_W-1:0]    acc_off_r, acc_off_nxt;
  logic [LEN_W-1:0]    acc_len_r, acc_len_nxt;
  logic [OFF_W-1:0]    f2_off_r, f2_off_nxt;
  logic [LEN_W-1:0]    f2_len_r, f2_len_nxt;
  logic [1:0]          rsel_r, rsel_nxt;
  logic [BYTE_W-1:0]   rd_r, rd_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                out_valid_r, out_valid_nxt;
  ptb_out_t            out_r, out_nxt;

  logic                tbl_we;
  logic [IDX_W-1:0]    tbl_wa, tbl_ra;
  logic [ENT_W-1:0]    tbl_wd, tbl_rd;
  logic                ost_we, ast_we;
  logic [OA_W-1:0]     ost_ra;
  logic [AA_W-1:0]     ast_ra;
  logic [BYTE_W-1:0]   ost_rd, ast_rd;

  logic                d_src;
  logic [OFF_W-1:0]    d_off;
  logic [LEN_W-1:0]    d_len;
  logic [CNT_W-1:0]    tail_idx;
  logic [4:0]          scan_cont;

  assign d_src    = tbl_rd[ENT_W-1];
  assign d_off    = tbl_rd[LEN_W +: OFF_W];
  assign d_len    = tbl_rd[LEN_W-1:0];
  assign tail_idx = used_r - CNT_W'(1);

  // Where a table scan hands over once it has found its piece or run out.
  always_comb begin
    case (req_r.op)
      OP_INSERT: scan_cont = S_CMID;
      OP_ERASE:  scan_cont = S_EPRE;
      default:   scan_cont = S_RFOUND;
    endcase
  end

  // Piece table and the two byte stores.
  ptb_ram #(.WIDTH(ENT_W), .DEPTH(MAX_PIECES)) u_table (
    .clk(clk), .wr_en(tbl_we), .wr_addr(tbl_wa), .wr_data(tbl_wd),
    .rd_addr(tbl_ra), .rd_data(tbl_rd)
  );

  ptb_ram #(.WIDTH(BYTE_W), .DEPTH(ORIGINAL_DEPTH)) u_orig (
    .clk(clk), .wr_en(ost_we), .wr_addr(ofill_r[OA_W-1:0]), .wr_data(req_r.data_byte),
    .rd_addr(ost_ra), .rd_data(ost_rd)
  );

  ptb_ram #(.WIDTH(BYTE_W), .DEPTH(APPEND_DEPTH)) u_app (
    .clk(clk), .wr_en(ast_we), .wr_addr(afill_r[AA_W-1:0]), .wr_data(req_r.data_byte),
    .rd_addr(ast_ra), .rd_data(ast_rd)
  );

  // Sequencer.
  always_comb begin
    logic [LEN_W-1:0] sum_v;
    logic [LEN_W-1:0] b_v;
    logic [LEN_W-1:0] end_v;
    logic [LEN_W-1:0] at_v;
    logic [LEN_W-1:0] cpos_v;
    logic [LEN_W-1:0] split_v;
    logic [POS_W-1:0] ins_pos;
    logic [AF_W-1:0]  ins_start;
    logic [AF_W-1:0]  ins_cnt;
    logic             whole_v, f1_v, f2_v;
    logic [LEN_W-1:0] f1_len, f2_len;
    logic [OFF_W-1:0] f2_off;
    logic             fv;
    logic             fs;
    logic [OFF_W-1:0] fo;
    logic [LEN_W-1:0] fl;
    logic [CNT_W:0]   wa_v;
    logic [31:0]      doc32;
    logic [31:0]      cnt32;
    logic [ENT_W-1:0] new_ent;

    state_nxt      = state_r;
    req_nxt        = req_r;
    doc_nxt        = doc_r;
    used_nxt       = used_r;
    ofill_nxt      = ofill_r;
    afill_nxt      = afill_r;
    pact_nxt       = pact_r;
    ppos_nxt       = ppos_r;
    pstart_nxt     = pstart_r;
    pcnt_nxt       = pcnt_r;
    cm_cnt_nxt     = cm_cnt_r;
    cm_pos_nxt     = cm_pos_r;
    idx_nxt        = idx_r;
    cons_nxt       = cons_r;
    key_nxt        = key_r;
    ge_nxt         = ge_r;
    found_nxt      = found_r;
    pi_nxt         = pi_r;
    p_src_nxt      = p_src_r;
    p_off_nxt      = p_off_r;
    p_len_nxt      = p_len_r;
    tail_match_nxt = tail_match_r;
    k_nxt          = k_r;
    at_nxt         = at_r;
    base_nxt       = base_r;
    n_nxt          = n_r;
    three_nxt      = three_r;
    step_nxt       = step_r;
    split_nxt      = split_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    w_nxt          = w_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    acc_v_nxt      = acc_v_r;
    acc_src_nxt    = acc_src_r;
    acc_off_nxt    = acc_off_r;
    acc_len_nxt    = acc_len_r;
    f2_off_nxt     = f2_off_r;
    f2_len_nxt     = f2_len_r;
    rsel_nxt       = rsel_r;
    rd_nxt         = rd_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r & out_stall;
    out_nxt        = out_r;

    tbl_we = 1'b0;
    tbl_wa = '0;
    tbl_wd = '0;
    tbl_ra = '0;
    ost_we = 1'b0;
    ast_we = 1'b0;
    ost_ra = '0;
    ast_ra = '0;

    sum_v   = cons_r + d_len;
    b_v     = a_r + d_len;
    new_ent = {1'b1, OFF_W'(pstart_r), LEN_W'(cm_cnt_r)};

    // Fragments of the current piece around the erased range.
    whole_v = (b_v <= lo_r) || (a_r >= hi_r);
    f1_v    = whole_v || (a_r < lo_r);
    f1_len  = whole_v ? d_len : (lo_r - a_r);
    f2_v    = !whole_v && (b_v > hi_r);
    f2_off  = OFF_W'(LEN_W'(d_off) + (hi_r - a_r));
    f2_len  = b_v - hi_r;

    // Merge accumulator: a fragment either extends the held piece or flushes it.
    fv = (state_r == S_ST_EV) ? f1_v : 1'b1;
    fs = (state_r == S_ST_EV) ? d_src : p_src_r;
    fo = (state_r == S_ST_EV) ? d_off : f2_off_r;
    fl = (state_r == S_ST_EV) ? f1_len : f2_len_r;
    if ((state_r == S_ST_EV || state_r == S_ST_F2) && fv) begin
      if (acc_v_r && acc_src_r == fs &&
          LEN_W'(acc_off_r) + acc_len_r == LEN_W'(fo)) begin
        acc_len_nxt = acc_len_r + fl;
      end else begin
        if (acc_v_r) begin
          tbl_we = 1'b1;
          tbl_wa = w_r[IDX_W-1:0];
          tbl_wd = {acc_src_r, acc_off_r, acc_len_r};
          w_nxt  = w_r + CNT_W'(1);
        end
        acc_v_nxt   = 1'b1;
        acc_src_nxt = fs;
        acc_off_nxt = fo;
        acc_len_nxt = fl;
      end
    end

    cpos_v  = (LEN_W'(ppos_r) > doc_r) ? doc_r : LEN_W'(ppos_r);
    split_v = cm_pos_r - cons_r;
    end_v   = LEN_W'(req_r.position) + LEN_W'(req_r.erase_length);
    at_v    = LEN_W'(p_off_r) + (key_r - cons_r);
    wa_v    = (CNT_W + 1)'(k_r) - (CNT_W + 1)'(1) + (CNT_W + 1)'(n_r);

    ins_pos   = pact_r ? ppos_r : req_r.position;
    ins_start = pact_r ? pstart_r : afill_r;
    ins_cnt   = pact_r ? pcnt_r : '0;

    doc32 = 32'(doc_r);
    cnt32 = 32'(used_r);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_data;
          status_nxt = ST_OK;
          rd_nxt     = '0;
          state_nxt  = S_GO;
        end
      end

      S_GO: begin
        case (req_r.op)
          OP_CLEAR: begin
            used_nxt   = '0;
            ofill_nxt  = '0;
            afill_nxt  = '0;
            doc_nxt    = '0;
            pact_nxt   = 1'b0;
            ppos_nxt   = '0;
            pstart_nxt = '0;
            pcnt_nxt   = '0;
            state_nxt  = S_DONE;
          end
          OP_LOAD: begin
            if (32'(ofill_r) >= ORIGINAL_DEPTH) begin
              status_nxt = ST_STORE_FULL;
              state_nxt  = S_DONE;
            end else if (used_r != '0) begin
              state_nxt = S_TAIL_RD;
            end else begin
              tail_match_nxt = 1'b0;
              state_nxt      = S_LOAD_FIN;
            end
          end
          OP_INSERT: begin
            pact_nxt   = 1'b1;
            ppos_nxt   = ins_pos;
            pstart_nxt = ins_start;
            if (32'(afill_r) >= APPEND_DEPTH) begin
              status_nxt = ST_STORE_FULL;
            end else begin
              ast_we    = 1'b1;
              afill_nxt = afill_r + AF_W'(1);
              ins_cnt   = ins_cnt + AF_W'(1);
            end
            pcnt_nxt = ins_cnt;
            if (req_r.last) begin
              pact_nxt   = 1'b0;
              pcnt_nxt   = '0;
              cm_cnt_nxt = ins_cnt;
              state_nxt  = S_CMT;
            end else begin
              state_nxt = S_DONE;
            end
          end
          OP_ERASE: begin
            idx_nxt   = '0;
            cons_nxt  = '0;
            found_nxt = 1'b0;
            w_nxt     = '0;
            a_nxt     = '0;
            acc_v_nxt = 1'b0;
            if (req_r.erase_length == '0) begin
              state_nxt = S_DONE;
            end else if (LEN_W'(req_r.position) < doc_r) begin
              lo_nxt    = LEN_W'(req_r.position);
              hi_nxt    = (end_v > doc_r) ? doc_r : end_v;
              key_nxt   = LEN_W'(req_r.position);
              ge_nxt    = 1'b0;
              state_nxt = S_SCAN_RD;
            end else begin
              lo_nxt    = doc_r;
              hi_nxt    = doc_r;
              state_nxt = S_ST_RD;
            end
          end
          OP_READ: begin
            if (LEN_W'(req_r.position) < doc_r) begin
              key_nxt   = LEN_W'(req_r.position);
              ge_nxt    = 1'b0;
              idx_nxt   = '0;
              cons_nxt  = '0;
              found_nxt = 1'b0;
              state_nxt = S_SCAN_RD;
            end else begin
              state_nxt = S_DONE;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      // Walk the table for the piece that holds the key position.
      S_SCAN_RD: begin
        if (idx_r == used_r) begin
          found_nxt = 1'b0;
          state_nxt = scan_cont;
        end else begin
          tbl_ra    = idx_r[IDX_W-1:0];
          state_nxt = S_SCAN_EV;
        end
      end

      S_SCAN_EV: begin
        if (ge_r ? (sum_v >= key_r) : (sum_v > key_r)) begin
          found_nxt = 1'b1;
          pi_nxt    = idx_r;
          p_src_nxt = d_src;
          p_off_nxt = d_off;
          p_len_nxt = d_len;
          state_nxt = scan_cont;
        end else begin
          cons_nxt  = sum_v;
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = S_SCAN_RD;
        end
      end

      // Fetch the last piece to see whether new text can extend it.
      S_TAIL_RD: begin
        tbl_ra    = tail_idx[IDX_W-1:0];
        state_nxt = S_TAIL_EV;
      end

      S_TAIL_EV: begin
        p_src_nxt = d_src;
        p_off_nxt = d_off;
        p_len_nxt = d_len;
        if (req_r.op == OP_LOAD) begin
          tail_match_nxt = !d_src && (LEN_W'(d_off) + d_len == LEN_W'(ofill_r));
          state_nxt      = S_LOAD_FIN;
        end else begin
          tail_match_nxt = d_src && (LEN_W'(d_off) + d_len == LEN_W'(pstart_r));
          state_nxt      = S_CEND_FIN;
        end
      end

      S_LOAD_FIN: begin
        state_nxt = S_DONE;
        if (tail_match_r) begin
          tbl_we = 1'b1;
          tbl_wa = tail_idx[IDX_W-1:0];
          tbl_wd = {p_src_r, p_off_r, p_len_r + LEN_W'(1)};
        end else if (32'(used_r) >= MAX_PIECES) begin
          status_nxt = ST_TABLE_FULL;
        end else begin
          tbl_we   = 1'b1;
          tbl_wa   = used_r[IDX_W-1:0];
          tbl_wd   = {1'b0, OFF_W'(ofill_r), LEN_W'(1)};
          used_nxt = used_r + CNT_W'(1);
        end
        if (tail_match_r || 32'(used_r) < MAX_PIECES) begin
          ost_we    = 1'b1;
          ofill_nxt = ofill_r + OF_W'(1);
          doc_nxt   = doc_r + LEN_W'(1);
        end
      end

      // Commit of a collected insert.
      S_CMT: begin
        cm_pos_nxt = cpos_v;
        if (cm_cnt_r == '0) begin
          state_nxt = S_DONE;
        end else if (cpos_v == doc_r) begin
          if (used_r != '0) begin
            state_nxt = S_TAIL_RD;
          end else begin
            tail_match_nxt = 1'b0;
            state_nxt      = S_CEND_FIN;
          end
        end else begin
          key_nxt   = cpos_v;
          ge_nxt    = 1'b1;
          idx_nxt   = '0;
          cons_nxt  = '0;
          found_nxt = 1'b0;
          state_nxt = S_SCAN_RD;
        end
      end

      S_CEND_FIN: begin
        state_nxt = S_DONE;
        if (tail_match_r) begin
          tbl_we  = 1'b1;
          tbl_wa  = tail_idx[IDX_W-1:0];
          tbl_wd  = {p_src_r, p_off_r, p_len_r + LEN_W'(cm_cnt_r)};
          doc_nxt = doc_r + LEN_W'(cm_cnt_r);
        end else if (32'(used_r) >= MAX_PIECES) begin
          status_nxt = ST_TABLE_FULL;
        end else begin
          tbl_we   = 1'b1;
          tbl_wa   = used_r[IDX_W-1:0];
          tbl_wd   = new_ent;
          used_nxt = used_r + CNT_W'(1);
          doc_nxt  = doc_r + LEN_W'(cm_cnt_r);
        end
      end

      // Choose the slots that the new piece needs inside the document.
      S_CMID: begin
        split_nxt = split_v;
        k_nxt     = used_r;
        step_nxt  = '0;
        if (!found_r) begin
          state_nxt = S_DONE;
        end else if (split_v != '0 && split_v < p_len_r) begin
          three_nxt = 1'b1;
          n_nxt     = 2'd2;
          at_nxt    = pi_r + CNT_W'(1);
          base_nxt  = pi_r;
          if (32'(used_r) + 2 > MAX_PIECES) begin
            status_nxt = ST_TABLE_FULL;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_SH_RD;
          end
        end else begin
          three_nxt = 1'b0;
          n_nxt     = 2'd1;
          at_nxt    = (split_v == '0) ? pi_r : pi_r + CNT_W'(1);
          base_nxt  = (split_v == '0) ? pi_r : pi_r + CNT_W'(1);
          if (32'(used_r) + 1 > MAX_PIECES) begin
            status_nxt = ST_TABLE_FULL;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_SH_RD;
          end
        end
      end

      // Move the table tail up by one or two slots, last entry first.
      S_SH_RD: begin
        if (k_r == at_r) begin
          state_nxt = S_PUT;
        end else begin
          tbl_ra    = IDX_W'(k_r - CNT_W'(1));
          state_nxt = S_SH_WR;
        end
      end

      S_SH_WR: begin
        tbl_we    = 1'b1;
        tbl_wa    = wa_v[IDX_W-1:0];
        tbl_wd    = tbl_rd;
        k_nxt     = k_r - CNT_W'(1);
        state_nxt = S_SH_RD;
      end

      // Write the new piece, and both halves of a split piece.
      S_PUT: begin
        tbl_we = 1'b1;
        tbl_wa = IDX_W'(base_r + CNT_W'(step_r));
        if (three_r && step_r == 2'd0) begin
          tbl_wd = {p_src_r, p_off_r, split_r};
        end else if (three_r && step_r == 2'd2) begin
          tbl_wd = {p_src_r, OFF_W'(LEN_W'(p_off_r) + split_r), p_len_r - split_r};
        end else begin
          tbl_wd = new_ent;
        end
        if (three_r ? (step_r == 2'd2) : (step_r == 2'd0)) begin
          used_nxt  = used_r + CNT_W'(n_r);
          doc_nxt   = doc_r + LEN_W'(cm_cnt_r);
          state_nxt = S_DONE;
        end else begin
          step_nxt = step_r + 2'd1;
        end
      end

      // An erase strictly inside one piece needs a free slot.
      S_EPRE: begin
        if (found_r && lo_r > cons_r && hi_r < cons_r + p_len_r &&
            32'(used_r) >= MAX_PIECES) begin
          status_nxt = ST_TABLE_FULL;
          state_nxt  = S_DONE;
        end else begin
          idx_nxt   = '0;
          state_nxt = S_ST_RD;
        end
      end

      // Rebuild the table without the erased range, merging as it goes.
      S_ST_RD: begin
        if (idx_r == used_r) begin
          state_nxt = S_ST_END;
        end else begin
          tbl_ra    = idx_r[IDX_W-1:0];
          state_nxt = S_ST_EV;
        end
      end

      S_ST_EV: begin
        p_src_nxt = d_src;
        if (f2_v) begin
          f2_off_nxt = f2_off;
          f2_len_nxt = f2_len;
          b_nxt      = b_v;
          state_nxt  = S_ST_F2;
        end else begin
          a_nxt     = b_v;
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = S_ST_RD;
        end
      end

      S_ST_F2: begin
        a_nxt     = b_r;
        idx_nxt   = idx_r + CNT_W'(1);
        state_nxt = S_ST_RD;
      end

      S_ST_END: begin
        if (acc_v_r) begin
          tbl_we = 1'b1;
          tbl_wa = w_r[IDX_W-1:0];
          tbl_wd = {acc_src_r, acc_off_r, acc_len_r};
        end
        used_nxt  = w_r + CNT_W'(acc_v_r);
        doc_nxt   = doc_r - (hi_r - lo_r);
        state_nxt = S_DONE;
      end

      // Byte fetch for a read request.
      S_RFOUND: begin
        state_nxt = S_DONE;
        if (found_r) begin
          if (!p_src_r) begin
            if (32'(at_v) < ORIGINAL_DEPTH) begin
              ost_ra    = at_v[OA_W-1:0];
              rsel_nxt  = RS_ORIG;
              state_nxt = S_RBYTE;
            end
          end else if (32'(at_v) < APPEND_DEPTH) begin
            ast_ra    = at_v[AA_W-1:0];
            rsel_nxt  = RS_APP;
            state_nxt = S_RBYTE;
          end
        end
      end

      S_RBYTE: begin
        rd_nxt    = (rsel_r == RS_ORIG) ? ost_rd : ast_rd;
        state_nxt = S_DONE;
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.read_byte   = rd_r;
          out_nxt.doc_length  = doc32[POS_W-1:0];
          out_nxt.status      = status_r;
          out_nxt.piece_count = cnt32[COUNT_W-1:0];
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      used_r      <= '0;
      ofill_r     <= '0;
      afill_r     <= '0;
      doc_r       <= '0;
      pact_r      <= 1'b0;
      ppos_r      <= '0;
      pstart_r    <= '0;
      pcnt_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      used_r      <= used_nxt;
      ofill_r     <= ofill_nxt;
      afill_r     <= afill_nxt;
      doc_r       <= doc_nxt;
      pact_r      <= pact_nxt;
      ppos_r      <= ppos_nxt;
      pstart_r    <= pstart_nxt;
      pcnt_r      <= pcnt_nxt;
    end
  end

  // Working registers of the sequencer.
  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    cm_cnt_r     <= cm_cnt_nxt;
    cm_pos_r     <= cm_pos_nxt;
    idx_r        <= idx_nxt;
    cons_r       <= cons_nxt;
    key_r        <= key_nxt;
    ge_r         <= ge_nxt;
    found_r      <= found_nxt;
    pi_r         <= pi_nxt;
    p_src_r      <= p_src_nxt;
    p_off_r      <= p_off_nxt;
    p_len_r      <= p_len_nxt;
    tail_match_r <= tail_match_nxt;
    k_r          <= k_nxt;
    at_r         <= at_nxt;
    base_r       <= base_nxt;
    n_r          <= n_nxt;
    three_r      <= three_nxt;
    step_r       <= step_nxt;
    split_r      <= split_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    w_r          <= w_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    acc_v_r      <= acc_v_nxt;
    acc_src_r    <= acc_src_nxt;
    acc_off_r    <= acc_off_nxt;
    acc_len_r    <= acc_len_nxt;
    f2_off_r     <= f2_off_nxt;
    f2_len_r     <= f2_len_nxt;
    rsel_r       <= rsel_nxt;
    rd_r         <= rd_nxt;
    status_r     <= status_nxt;
    out_r        <= out_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
